@@ hw/rtl/chip8_pkg.sv @@
// ----------------------------------------------------------------------------
// chip8_pkg
// shared types, constants and the font table of the chip8 execute unit
// ----------------------------------------------------------------------------
package chip8_pkg;

	localparam int MEMORY_BYTES  = 4096;
	localparam int PROGRAM_START = 512;
	localparam int GLYPH_HEIGHT  = 5;
	localparam int STACK_DEPTH   = 16;
	localparam int FRAME_WIDTH   = 64;
	localparam int FRAME_HEIGHT  = 32;
	localparam int FONT_BYTES    = 16 * GLYPH_HEIGHT;
	localparam int SP_W          = $clog2(STACK_DEPTH + 1);
	localparam int STK_AW        = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	localparam logic [1:0] CMD_EXEC = 2'd0;
	localparam logic [1:0] CMD_LOAD = 2'd1;
	localparam logic [1:0] CMD_ROW  = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_OVER  = 2'd1;
	localparam logic [1:0] STAT_UNDER = 2'd2;

	localparam logic [15:0] OP_CLS = 16'h00E0;
	localparam logic [15:0] OP_RET = 16'h00EE;
	localparam logic [7:0]  KK_DT_RD  = 8'h07;
	localparam logic [7:0]  KK_KEY    = 8'h0A;
	localparam logic [7:0]  KK_DT_WR  = 8'h15;
	localparam logic [7:0]  KK_ST_WR  = 8'h18;
	localparam logic [7:0]  KK_I_ADD  = 8'h1E;
	localparam logic [7:0]  KK_FONT   = 8'h29;
	localparam logic [7:0]  KK_BCD    = 8'h33;
	localparam logic [7:0]  KK_STORE  = 8'h55;
	localparam logic [7:0]  KK_LOAD   = 8'h65;
	localparam logic [7:0]  KK_SKP    = 8'h9E;
	localparam logic [7:0]  KK_SKNP   = 8'hA1;

	localparam logic [7:0] FONT [0:FONT_BYTES-1] = '{
		8'hf0, 8'h90, 8'h90, 8'h90, 8'hf0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
		8'hf0, 8'h10, 8'hf0, 8'h80, 8'hf0, 8'hf0, 8'h10, 8'hf0, 8'h10, 8'hf0,
		8'h90, 8'h90, 8'hf0, 8'h10, 8'h10, 8'hf0, 8'h80, 8'hf0, 8'h10, 8'hf0,
		8'hf0, 8'h80, 8'hf0, 8'h90, 8'hf0, 8'hf0, 8'h10, 8'h20, 8'h40, 8'h40,
		8'hf0, 8'h90, 8'hf0, 8'h90, 8'hf0, 8'hf0, 8'h90, 8'hf0, 8'h10, 8'hf0,
		8'hf0, 8'h90, 8'hf0, 8'h90, 8'h90, 8'he0, 8'h90, 8'he0, 8'h90, 8'he0,
		8'hf0, 8'h80, 8'h80, 8'h80, 8'hf0, 8'he0, 8'h90, 8'h90, 8'h90, 8'he0,
		8'hf0, 8'h80, 8'hf0, 8'h80, 8'hf0, 8'hf0, 8'h80, 8'hf0, 8'h80, 8'h80
	};

	function automatic logic [7:0] font_byte(input logic [11:0] a);
		logic [7:0] b;
		b = 8'h00;
		if (a < 12'(FONT_BYTES)) begin
			b = FONT[a[6:0]];
		end
		return b;
	endfunction

	typedef enum logic [3:0] {
		PH_CLEAR,
		PH_IDLE,
		PH_RDX,
		PH_RDY,
		PH_EXEC,
		PH_DRAW_RD,
		PH_DRAW_WR,
		PH_BCD,
		PH_STORE,
		PH_LOAD_RD,
		PH_LOAD_WR,
		PH_OUT
	} phase_t;

	typedef enum logic [2:0] {
		LOOP_NONE,
		LOOP_DRAW,
		LOOP_BCD,
		LOOP_STORE,
		LOOP_LOAD
	} loop_kind_t;

	typedef struct packed {
		phase_t phase;
		logic   take;
		logic   load_out;
	} ctl_t;

	typedef struct packed {
		logic       clr_done;
		loop_kind_t kind;
		logic       last;
	} stat_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] opcode;
		logic [11:0] load_address;
		logic [7:0]  load_byte;
		logic [4:0]  row_index;
		logic [7:0]  random_byte;
		logic [15:0] keys_down;
		logic [3:0]  wait_key;
	} in_item_t;

	typedef struct packed {
		logic [11:0] next_pc;
		logic [7:0]  flag_value;
		logic [63:0] screen_row;
		logic        sound_on;
		logic [1:0]  status;
	} out_item_t;

endpackage

@@ hw/rtl/chip8_ctrl.sv @@
// ----------------------------------------------------------------------------
// chip8_ctrl
// sequencer: memory clear, operand reads, execute, loops and result hand-off
// ----------------------------------------------------------------------------
module chip8_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  chip8_pkg::stat_t stat,
	output chip8_pkg::ctl_t  ctl
);

	chip8_pkg::phase_t state_q, state_d;
	logic              ov_q, ov_d, out_free;

	assign out_free = !ov_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			chip8_pkg::PH_CLEAR: if (stat.clr_done) state_d = chip8_pkg::PH_IDLE;
			chip8_pkg::PH_IDLE: if (in_valid) state_d = chip8_pkg::PH_RDX;
			chip8_pkg::PH_RDX: state_d = chip8_pkg::PH_RDY;
			chip8_pkg::PH_RDY: state_d = chip8_pkg::PH_EXEC;
			chip8_pkg::PH_EXEC: begin
				unique case (stat.kind)
					chip8_pkg::LOOP_DRAW:  state_d = chip8_pkg::PH_DRAW_RD;
					chip8_pkg::LOOP_BCD:   state_d = chip8_pkg::PH_BCD;
					chip8_pkg::LOOP_STORE: state_d = chip8_pkg::PH_STORE;
					chip8_pkg::LOOP_LOAD:  state_d = chip8_pkg::PH_LOAD_RD;
					default:               state_d = chip8_pkg::PH_OUT;
				endcase
			end
			chip8_pkg::PH_DRAW_RD: state_d = chip8_pkg::PH_DRAW_WR;
			chip8_pkg::PH_DRAW_WR: begin
				state_d = stat.last ? chip8_pkg::PH_OUT : chip8_pkg::PH_DRAW_RD;
			end
			chip8_pkg::PH_BCD: if (stat.last) state_d = chip8_pkg::PH_OUT;
			chip8_pkg::PH_STORE: if (stat.last) state_d = chip8_pkg::PH_OUT;
			chip8_pkg::PH_LOAD_RD: state_d = chip8_pkg::PH_LOAD_WR;
			chip8_pkg::PH_LOAD_WR: begin
				state_d = stat.last ? chip8_pkg::PH_OUT : chip8_pkg::PH_LOAD_RD;
			end
			chip8_pkg::PH_OUT: if (out_free) state_d = chip8_pkg::PH_IDLE;
			default: state_d = chip8_pkg::PH_CLEAR;
		endcase
	end

	always_comb begin
		ctl.phase    = state_q;
		ctl.take     = (state_q == chip8_pkg::PH_IDLE) && in_valid;
		ctl.load_out = (state_q == chip8_pkg::PH_OUT) && out_free;
		in_ready     = (state_q == chip8_pkg::PH_IDLE);
		out_valid    = ov_q;
		ov_d         = ctl.load_out ? 1'b1 : (ov_q && !out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chip8_pkg::PH_CLEAR;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			ov_q    <= ov_d;
		end
	end

endmodule

@@ hw/rtl/chip8_dpath.sv @@
// ----------------------------------------------------------------------------
// chip8_dpath
// architectural state, main memory, frame buffer and execute logic
// ----------------------------------------------------------------------------
module chip8_dpath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  chip8_pkg::ctl_t      ctl,
	input  chip8_pkg::in_item_t  in_data,
	output chip8_pkg::stat_t     stat,
	output chip8_pkg::out_item_t out_data
);

	chip8_pkg::in_item_t  item_q;
	chip8_pkg::out_item_t out_q;

	logic [7:0]  mem [chip8_pkg::MEMORY_BYTES];
	logic [7:0]  mrd_q;
	logic [7:0]  vreg_q [16];
	logic [11:0] stk_q [chip8_pkg::STACK_DEPTH];
	logic [63:0] frame_q [chip8_pkg::FRAME_HEIGHT];
	logic [15:0] i_q;
	logic [11:0] pc_q;
	logic [chip8_pkg::SP_W-1:0] sp_q, sp_m1;
	logic [7:0]  dly_q, snd_q, vx_q, vy_q;
	logic [4:0]  cnt_q;
	logic        hit_q;
	logic [1:0]  st_q;
	logic [11:0] clr_q;

	logic [3:0]  op, x, y, n, rd_addr;
	logic [7:0]  kk, vrd;
	logic [11:0] nnn, pc2, pc4, stk_top;
	logic [15:0] isum;
	logic        is_exec, skip, key_vx, sp_full;
	logic        mwe;
	logic [11:0] mwa;
	logic [7:0]  mwd;
	logic [1:0]  bcd_h;
	logic [7:0]  bcd_r, bcd_o, dig;
	logic [14:0] bcd_m;
	logic [3:0]  bcd_t;
	logic [4:0]  frow_addr;
	logic [63:0] frow, spr, pat;
	logic [5:0]  sh;
	logic [7:0]  alu_res;
	logic        alu_fl, alu_we, alu_fwe;
	logic [8:0]  add9;

	assign op      = item_q.opcode[15:12];
	assign x       = item_q.opcode[11:8];
	assign y       = item_q.opcode[7:4];
	assign n       = item_q.opcode[3:0];
	assign kk      = item_q.opcode[7:0];
	assign nnn     = item_q.opcode[11:0];
	assign is_exec = (item_q.command == chip8_pkg::CMD_EXEC);
	assign pc2     = pc_q + 12'd2;
	assign pc4     = pc_q + 12'd4;
	assign isum    = i_q + 16'(cnt_q);
	assign sp_m1   = sp_q - 1'b1;
	assign stk_top = stk_q[sp_m1[chip8_pkg::STK_AW-1:0]];
	assign sp_full = (sp_q >= chip8_pkg::SP_W'(chip8_pkg::STACK_DEPTH));
	assign key_vx  = (vx_q < 8'd16) && item_q.keys_down[vx_q[3:0]];

	always_comb begin
		stat.clr_done = (clr_q == 12'hFFF);
		stat.kind     = chip8_pkg::LOOP_NONE;
		stat.last     = 1'b0;
		if (is_exec && op == 4'hD && n != 4'h0) begin
			stat.kind = chip8_pkg::LOOP_DRAW;
		end else if (is_exec && op == 4'hF && kk == chip8_pkg::KK_BCD) begin
			stat.kind = chip8_pkg::LOOP_BCD;
		end else if (is_exec && op == 4'hF && kk == chip8_pkg::KK_STORE) begin
			stat.kind = chip8_pkg::LOOP_STORE;
		end else if (is_exec && op == 4'hF && kk == chip8_pkg::KK_LOAD) begin
			stat.kind = chip8_pkg::LOOP_LOAD;
		end
		unique case (stat.kind)
			chip8_pkg::LOOP_DRAW: stat.last = (cnt_q == 5'({1'b0, n} - 5'd1));
			chip8_pkg::LOOP_BCD:  stat.last = (cnt_q == 5'd2);
			chip8_pkg::LOOP_STORE,
			chip8_pkg::LOOP_LOAD: stat.last = (cnt_q == {1'b0, x});
			default:              stat.last = 1'b0;
		endcase
	end

	// register file read port
	always_comb begin
		unique case (ctl.phase)
			chip8_pkg::PH_RDX:   rd_addr = x;
			chip8_pkg::PH_RDY:   rd_addr = (op == 4'hB) ? 4'h0 : y;
			chip8_pkg::PH_STORE: rd_addr = cnt_q[3:0];
			default:             rd_addr = x;
		endcase
	end
	assign vrd = vreg_q[rd_addr];

	// decimal digits
	always_comb begin
		bcd_h = (vx_q >= 8'd200) ? 2'd2 : ((vx_q >= 8'd100) ? 2'd1 : 2'd0);
		bcd_r = vx_q - 8'(bcd_h) * 8'd100;
		bcd_m = 15'(bcd_r) * 15'd205;
		bcd_t = bcd_m[14:11];
		bcd_o = bcd_r - 8'(bcd_t) * 8'd10;
		unique case (cnt_q[1:0])
			2'd0:    dig = 8'(bcd_h);
			2'd1:    dig = 8'(bcd_t);
			default: dig = bcd_o;
		endcase
	end

	// memory write port
	always_comb begin
		mwe = 1'b0;
		mwa = isum[11:0];
		mwd = vrd;
		unique case (ctl.phase)
			chip8_pkg::PH_CLEAR: begin
				mwe = 1'b1;
				mwa = clr_q;
				mwd = chip8_pkg::font_byte(clr_q);
			end
			chip8_pkg::PH_EXEC: begin
				mwe = (item_q.command == chip8_pkg::CMD_LOAD);
				mwa = item_q.load_address;
				mwd = item_q.load_byte;
			end
			chip8_pkg::PH_BCD: begin
				mwe = 1'b1;
				mwd = dig;
			end
			chip8_pkg::PH_STORE: mwe = 1'b1;
			default: mwe = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mwe) begin
			mem[mwa] <= mwd;
		end
		mrd_q <= mem[isum[11:0]];
	end

	// sprite row
	assign frow_addr = (ctl.phase == chip8_pkg::PH_DRAW_WR) ?
		(vy_q[4:0] + cnt_q) : item_q.row_index;
	assign frow = frame_q[frow_addr];
	assign spr  = {mrd_q, 56'd0};
	assign sh   = vx_q[5:0];
	assign pat  = (spr >> sh) | (spr << (7'd64 - {1'b0, sh}));

	// 8xyN
	always_comb begin
		add9    = {1'b0, vx_q} + {1'b0, vy_q};
		alu_res = vx_q;
		alu_fl  = 1'b0;
		alu_we  = 1'b1;
		alu_fwe = 1'b1;
		unique case (n)
			4'h0: begin alu_res = vy_q; alu_fwe = 1'b0; end
			4'h1: begin alu_res = vx_q | vy_q; alu_fwe = 1'b0; end
			4'h2: begin alu_res = vx_q & vy_q; alu_fwe = 1'b0; end
			4'h3: begin alu_res = vx_q ^ vy_q; alu_fwe = 1'b0; end
			4'h4: begin alu_res = add9[7:0]; alu_fl = add9[8]; end
			4'h5: begin alu_res = vx_q - vy_q; alu_fl = vx_q > vy_q; end
			4'h6: begin alu_res = {1'b0, vx_q[7:1]}; alu_fl = vx_q[0]; end
			4'h7: begin alu_res = vy_q - vx_q; alu_fl = vy_q > vx_q; end
			4'hE: begin alu_res = {vx_q[6:0], 1'b0}; alu_fl = vx_q[7]; end
			default: begin alu_we = 1'b0; alu_fwe = 1'b0; end
		endcase
	end

	always_comb begin
		unique case (op)
			4'h3: skip = (vx_q == kk);
			4'h4: skip = (vx_q != kk);
			4'h5: skip = (vx_q == vy_q);
			4'h9: skip = (vx_q != vy_q);
			4'hE: skip = ((kk == chip8_pkg::KK_SKP) && key_vx) ||
				((kk == chip8_pkg::KK_SKNP) && !key_vx);
			default: skip = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			item_q <= in_data;
		end
		if (ctl.phase == chip8_pkg::PH_EXEC && is_exec && op == 4'h2 &&
			item_q.opcode != chip8_pkg::OP_CLS && !sp_full) begin
			stk_q[sp_q[chip8_pkg::STK_AW-1:0]] <= pc2;
		end
		if (ctl.load_out) begin
			out_q.next_pc    <= pc_q;
			out_q.flag_value <= vreg_q[15];
			out_q.screen_row <= (item_q.command == chip8_pkg::CMD_ROW) ? frow : 64'd0;
			out_q.sound_on   <= (snd_q != 8'd0);
			out_q.status     <= st_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 16; r++) vreg_q[r] <= 8'd0;
			for (int r = 0; r < chip8_pkg::FRAME_HEIGHT; r++) frame_q[r] <= 64'd0;
			i_q   <= 16'd0;
			pc_q  <= 12'(chip8_pkg::PROGRAM_START);
			sp_q  <= '0;
			dly_q <= 8'd0;
			snd_q <= 8'd0;
			vx_q  <= 8'd0;
			vy_q  <= 8'd0;
			cnt_q <= 5'd0;
			hit_q <= 1'b0;
			st_q  <= chip8_pkg::STAT_OK;
			clr_q <= 12'd0;
		end else begin
			unique case (ctl.phase)
				chip8_pkg::PH_CLEAR: clr_q <= clr_q + 12'd1;
				chip8_pkg::PH_IDLE: if (ctl.take) st_q <= chip8_pkg::STAT_OK;
				chip8_pkg::PH_RDX: vx_q <= vrd;
				chip8_pkg::PH_RDY: vy_q <= vrd;
				chip8_pkg::PH_EXEC: begin
					cnt_q <= 5'd0;
					hit_q <= 1'b0;
					if (item_q.command == chip8_pkg::CMD_LOAD) begin
						pc_q <= 12'(chip8_pkg::PROGRAM_START);
					end else if (is_exec) begin
						pc_q <= skip ? pc4 : pc2;
						if (item_q.opcode == chip8_pkg::OP_CLS) begin
							for (int r = 0; r < chip8_pkg::FRAME_HEIGHT; r++) frame_q[r] <= 64'd0;
						end else if (item_q.opcode == chip8_pkg::OP_RET) begin
							if (sp_q == '0) begin
								st_q <= chip8_pkg::STAT_UNDER;
							end else begin
								sp_q <= sp_m1;
								pc_q <= stk_top;
							end
						end else begin
							unique case (op)
								4'h1: pc_q <= nnn;
								4'h2: begin
									if (sp_full) begin
										st_q <= chip8_pkg::STAT_OVER;
									end else begin
										sp_q <= sp_q + 1'b1;
										pc_q <= nnn;
									end
								end
								4'h6: vreg_q[x] <= kk;
								4'h7: vreg_q[x] <= vx_q + kk;
								4'h8: begin
									if (alu_we) vreg_q[x] <= alu_res;
									if (alu_fwe) vreg_q[15] <= {7'd0, alu_fl};
								end
								4'hA: i_q <= {4'd0, nnn};
								4'hB: pc_q <= nnn + {4'd0, vy_q};
								4'hC: vreg_q[x] <= ((item_q.random_byte == 8'hFF) ?
									8'd0 : item_q.random_byte) & kk;
								4'hD: if (n == 4'h0) vreg_q[15] <= 8'd0;
								4'hF: begin
									unique case (kk)
										chip8_pkg::KK_DT_RD: vreg_q[x] <= dly_q;
										chip8_pkg::KK_KEY: vreg_q[x] <= {4'd0, item_q.wait_key};
										chip8_pkg::KK_DT_WR: dly_q <= vx_q;
										chip8_pkg::KK_ST_WR: snd_q <= vx_q;
										chip8_pkg::KK_I_ADD: i_q <= i_q + {8'd0, vx_q};
										chip8_pkg::KK_FONT: i_q <= {6'd0, vx_q, 2'd0} + {8'd0, vx_q};
										default: ;
									endcase
								end
								default: ;
							endcase
						end
					end
				end
				chip8_pkg::PH_DRAW_WR: begin
					frame_q[frow_addr] <= frow ^ pat;
					hit_q <= hit_q | (|(frow & pat));
					cnt_q <= cnt_q + 5'd1;
					if (stat.last) vreg_q[15] <= {7'd0, hit_q | (|(frow & pat))};
				end
				chip8_pkg::PH_BCD, chip8_pkg::PH_STORE: cnt_q <= cnt_q + 5'd1;
				chip8_pkg::PH_LOAD_WR: begin
					vreg_q[cnt_q[3:0]] <= mrd_q;
					cnt_q <= cnt_q + 5'd1;
				end
				default: ;
			endcase
		end
	end

	assign out_data = out_q;

endmodule

@@ hw/rtl/chip8_instruction_executor_top.sv @@
// ----------------------------------------------------------------------------
// chip8_instruction_executor_top
// chip8 execute unit: runs one instruction, loads one byte or reads one row
// ----------------------------------------------------------------------------
// in channel: in_valid/in_ready with in_data; command execute, load byte or
// read screen row. out channel: out_valid/out_ready with out_data, one item
// per input item carrying pc, vf, screen row, sound flag and stack status.
// one item is worked on at a time; in_ready is high only while idle.
// after accept the operand registers are read, the instruction executes, and
// sprite, bcd, register store and register load instructions then loop over
// their rows, digits or registers; sprite rows and register loads each take a
// memory read step and a write step. in_ready returns in the cycle after the
// result is loaded. a new item can be taken while a finished result still
// waits.
// after reset the block writes the font and zeroes the rest of main memory,
// with in_ready low; pc starts at 512.
// if the receiver stalls, the result is held in the output register and
// the next item stops in its last cycle until the register frees.
// ----------------------------------------------------------------------------
module chip8_instruction_executor_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  chip8_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output chip8_pkg::out_item_t out_data
);

	chip8_pkg::ctl_t  ctl;
	chip8_pkg::stat_t stat;

	chip8_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	chip8_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.in_data  (in_data),
		.stat     (stat),
		.out_data (out_data)
	);

endmodule

@@ hw/rtl/chip8_checker.sv @@
// ----------------------------------------------------------------------------
// chip8_checker
// port level checks of the chip8 execute unit
// ----------------------------------------------------------------------------
module chip8_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input chip8_pkg::in_item_t  in_data,
	input logic                 out_valid,
	input logic                 out_ready,
	input chip8_pkg::out_item_t out_data
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("input item changed while waiting");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while busy");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status != 2'd3)
		else $error("bad status code");

	a_row_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != chip8_pkg::STAT_OK |-> out_data.screen_row == 64'd0)
		else $error("row data on a stack error item");

endmodule

bind chip8_instruction_executor_top chip8_checker u_chip8_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

@@ tb/sv/tb_chip8_instruction_executor_top.sv @@
// ----------------------------------------------------------------------------
// tb_chip8_instruction_executor_top
// self-checking bench for the chip8 execute unit: a queue-fed driver pushes
// load, execute and row-read items, a predictor tracks the machine state and
// a monitor compares every result item field by field in order
// ----------------------------------------------------------------------------
module tb_chip8_instruction_executor_top;
	timeunit 1ns;
	timeprecision 1ps;
	import chip8_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out_data;

	chip8_instruction_executor_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	logic [7:0]  mem [0:MEMORY_BYTES-1];
	logic [7:0]  vreg [0:15];
	logic [15:0] ireg;
	logic [11:0] pc;
	logic [11:0] rstack [0:STACK_DEPTH-1];
	int          sp;
	logic [7:0]  delay_cnt;
	logic [7:0]  sound_cnt;
	logic [63:0] frame [0:FRAME_HEIGHT-1];

	in_item_t  pending_items [$];
	out_item_t expected_results [$];
	int  fails;
	int  cycles;
	int  send_idle_pct;
	int  recv_idle_pct;
	int  hold_cycles;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [11:0] pc_skip(input logic [11:0] p);
		return p + 12'd2;
	endfunction

	function automatic logic key_held(input logic [7:0] k, input logic [15:0] keys);
		if (k > 8'd15) begin
			return 1'b0;
		end
		return keys[k[3:0]];
	endfunction

	function automatic logic [7:0] sprite_draw(input logic [7:0] x0, input logic [7:0] y0,
			input int n);
		logic [7:0] hit;
		logic [7:0] bits;
		int row;
		int col;
		hit = 8'd0;
		for (int r = 0; r < n; r++) begin
			bits = mem[12'(ireg + 16'(r))];
			row = (int'(y0) + r) % FRAME_HEIGHT;
			for (int c = 0; c < 8; c++) begin
				if (bits[7-c]) begin
					col = (int'(x0) + c) % FRAME_WIDTH;
					if (frame[row][63-col]) hit = 8'd1;
					frame[row][63-col] = ~frame[row][63-col];
				end
			end
		end
		return hit;
	endfunction

	function automatic void alu_step(input int x, input int y, input logic [3:0] op);
		logic [7:0] vx;
		logic [7:0] vy;
		logic [7:0] res;
		logic [7:0] fl;
		bit sets;
		vx = vreg[x];
		vy = vreg[y];
		fl = 8'd0;
		sets = 1'b1;
		case (op)
			4'h0: begin res = vy; sets = 1'b0; end
			4'h1: begin res = vx | vy; sets = 1'b0; end
			4'h2: begin res = vx & vy; sets = 1'b0; end
			4'h3: begin res = vx ^ vy; sets = 1'b0; end
			4'h4: begin res = vx + vy; fl = 8'((9'(vx) + 9'(vy)) > 9'd255); end
			4'h5: begin res = vx - vy; fl = 8'(vx > vy); end
			4'h6: begin res = vx >> 1; fl = 8'(vx[0]); end
			4'h7: begin res = vy - vx; fl = 8'(vy > vx); end
			4'hE: begin res = vx << 1; fl = 8'(vx[7]); end
			default: return;
		endcase
		vreg[x] = res;
		if (sets) vreg[15] = fl;
	endfunction

	function automatic void misc_step(input int x, input logic [7:0] kk, input in_item_t it);
		logic [7:0] vx;
		vx = vreg[x];
		case (kk)
			KK_DT_RD: vreg[x] = delay_cnt;
			KK_KEY:   vreg[x] = 8'(it.wait_key);
			KK_DT_WR: delay_cnt = vx;
			KK_ST_WR: sound_cnt = vx;
			KK_I_ADD: ireg = ireg + 16'(vx);
			KK_FONT:  ireg = 16'(vx) * 16'(GLYPH_HEIGHT);
			KK_BCD: begin
				mem[12'(ireg)] = vx / 100;
				mem[12'(ireg + 16'd1)] = (vx / 10) % 10;
				mem[12'(ireg + 16'd2)] = vx % 10;
			end
			KK_STORE: for (int i = 0; i <= x; i++) mem[12'(ireg + 16'(i))] = vreg[i];
			KK_LOAD:  for (int i = 0; i <= x; i++) vreg[i] = mem[12'(ireg + 16'(i))];
			default: ;
		endcase
	endfunction

	function automatic logic [1:0] run_opcode(input in_item_t it);
		logic [15:0] op;
		int x;
		int y;
		logic [7:0] kk;
		logic [7:0] vx;
		logic [7:0] vy;
		logic [1:0] st;
		op = it.opcode;
		x = op[11:8];
		y = op[7:4];
		kk = op[7:0];
		vx = vreg[x];
		vy = vreg[y];
		st = STAT_OK;
		pc = pc_skip(pc);
		if (op == OP_CLS) begin
			for (int r = 0; r < FRAME_HEIGHT; r++) frame[r] = '0;
			return STAT_OK;
		end
		if (op == OP_RET) begin
			if (sp == 0) return STAT_UNDER;
			sp--;
			pc = rstack[sp];
			return STAT_OK;
		end
		case (op[15:12])
			4'h1: pc = op[11:0];
			4'h2: begin
				if (sp >= STACK_DEPTH) begin
					st = STAT_OVER;
				end else begin
					rstack[sp] = pc;
					sp++;
					pc = op[11:0];
				end
			end
			4'h3: if (vx == kk) pc = pc_skip(pc);
			4'h4: if (vx != kk) pc = pc_skip(pc);
			4'h5: if (vx == vy) pc = pc_skip(pc);
			4'h6: vreg[x] = kk;
			4'h7: vreg[x] = vx + kk;
			4'h8: alu_step(x, y, op[3:0]);
			4'h9: if (vx != vy) pc = pc_skip(pc);
			4'hA: ireg = 16'(op[11:0]);
			4'hB: pc = op[11:0] + 12'(vreg[0]);
			4'hC: vreg[x] = 8'(it.random_byte % 255) & kk;
			4'hD: vreg[15] = sprite_draw(vx, vy, op[3:0]);
			4'hE: begin
				if ((kk == KK_SKP && key_held(vx, it.keys_down)) ||
						(kk == KK_SKNP && !key_held(vx, it.keys_down)))
					pc = pc_skip(pc);
			end
			4'hF: misc_step(x, kk, it);
			default: ;
		endcase
		return st;
	endfunction

	function automatic out_item_t predict_result(input in_item_t it);
		out_item_t r;
		r = '0;
		if (it.command == CMD_EXEC) begin
			r.status = run_opcode(it);
		end else if (it.command == CMD_LOAD) begin
			mem[it.load_address] = it.load_byte;
			pc = 12'(PROGRAM_START);
		end else if (it.command == CMD_ROW) begin
			r.screen_row = frame[it.row_index];
		end
		r.next_pc = pc;
		r.flag_value = vreg[15];
		r.sound_on = sound_cnt != 8'd0;
		return r;
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		it.command = 2'($urandom_range(0, 3));
		it.opcode = 16'($urandom);
		it.load_address = 12'($urandom);
		it.load_byte = 8'($urandom);
		it.row_index = 5'($urandom);
		it.random_byte = 8'($urandom);
		it.keys_down = 16'($urandom);
		it.wait_key = 4'($urandom);
		return it;
	endfunction

	function automatic in_item_t exec_item(input logic [15:0] op);
		in_item_t it;
		it = random_item();
		it.command = CMD_EXEC;
		it.opcode = op;
		return it;
	endfunction

	// mostly well-formed programs: registers, alu, index, sprites, stack, keys, timers, loads, rows
	function automatic in_item_t program_item();
		in_item_t it;
		logic [15:0] op;
		int pick;
		pick = $urandom_range(0, 99);
		op = 16'($urandom);
		if (pick < 8) begin
			it = random_item();
			it.command = CMD_ROW;
			return it;
		end else if (pick < 12) begin
			it = random_item();
			it.command = CMD_LOAD;
			return it;
		end else if (pick < 16) begin
			it = random_item();
			return it;
		end else if (pick < 26) begin
			op[15:12] = 4'h6;
		end else if (pick < 36) begin
			op[15:12] = 4'h8;
			op[3:0] = ($urandom_range(0, 9) == 9) ? 4'hE : 4'($urandom_range(0, 8));
		end else if (pick < 46) begin
			op[15:12] = 4'hD;
			if ($urandom_range(0, 3) != 0) op[3:0] = 4'($urandom_range(0, 5));
		end else if (pick < 52) begin
			op[15:12] = 4'hA;
			if ($urandom_range(0, 3) != 0) op[11:0] = 12'($urandom_range(0, 95));
		end else if (pick < 58) begin
			op = {4'h2, 12'($urandom)};
		end else if (pick < 66) begin
			op = OP_RET;
		end else if (pick < 68) begin
			op = OP_CLS;
		end else if (pick < 84) begin
			op[15:12] = 4'hF;
			case ($urandom_range(0, 10))
				0: op[7:0] = KK_DT_RD;
				1: op[7:0] = KK_KEY;
				2: op[7:0] = KK_DT_WR;
				3: op[7:0] = KK_ST_WR;
				4: op[7:0] = KK_I_ADD;
				5: op[7:0] = KK_FONT;
				6: op[7:0] = KK_BCD;
				7: op[7:0] = KK_STORE;
				8: op[7:0] = KK_LOAD;
				default: ;
			endcase
		end else if (pick < 90) begin
			op[15:12] = 4'hE;
			op[7:0] = $urandom_range(0, 1) ? KK_SKP : KK_SKNP;
		end
		return exec_item(op);
	endfunction

	task automatic queue_directed();
		in_item_t it;
		it = random_item(); it.command = CMD_ROW; it.row_index = 5'd0;
		pending_items.push_back(it);
		it = random_item(); it.command = CMD_LOAD; it.load_address = 12'hFFF;
		it.load_byte = 8'hFF;
		pending_items.push_back(it);
		it = random_item(); it.command = 2'd3;
		pending_items.push_back(it);
		pending_items.push_back(exec_item(OP_RET));
		pending_items.push_back(exec_item(16'h60FF));
		pending_items.push_back(exec_item(16'h61FF));
		pending_items.push_back(exec_item(16'h8F14));
		pending_items.push_back(exec_item(16'h8015));
		pending_items.push_back(exec_item(16'h8017));
		pending_items.push_back(exec_item(16'h810E));
		pending_items.push_back(exec_item(16'h8F06));
		pending_items.push_back(exec_item(16'hA000));
		pending_items.push_back(exec_item(16'hD005));
		pending_items.push_back(exec_item(16'hD005));
		pending_items.push_back(exec_item(16'hD000));
		pending_items.push_back(exec_item(16'hF029));
		pending_items.push_back(exec_item(16'hE09E));
		pending_items.push_back(exec_item(16'hE0A1));
		pending_items.push_back(exec_item(16'hF133));
		pending_items.push_back(exec_item(16'hFF55));
		pending_items.push_back(exec_item(16'hFF65));
		pending_items.push_back(exec_item(16'hBFFF));
		for (int i = 0; i <= STACK_DEPTH; i++) pending_items.push_back(exec_item(16'h2FFE));
		pending_items.push_back(exec_item(OP_CLS));
		it = random_item(); it.command = CMD_ROW; it.row_index = 5'd31;
		pending_items.push_back(it);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else if (!in_valid || in_ready) begin
			if (in_valid) expected_results.push_back(predict_result(in_data));
			if (pending_items.size() > 0 && $urandom_range(1, 100) > send_idle_pct) begin
				in_valid <= 1'b1;
				in_data <= pending_items.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_ready <= ($urandom_range(1, 100) > recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected item %p", $realtime, out_data);
				fails++;
			end else begin
				out_item_t e;
				e = expected_results.pop_front();
				if (e.next_pc !== out_data.next_pc)
					$display("%0t: next_pc exp %h got %h", $realtime, e.next_pc,
						out_data.next_pc);
				if (e.flag_value !== out_data.flag_value)
					$display("%0t: flag_value exp %h got %h", $realtime, e.flag_value,
						out_data.flag_value);
				if (e.screen_row !== out_data.screen_row)
					$display("%0t: screen_row exp %h got %h", $realtime, e.screen_row,
						out_data.screen_row);
				if (e.sound_on !== out_data.sound_on)
					$display("%0t: sound_on exp %b got %b", $realtime, e.sound_on,
						out_data.sound_on);
				if (e.status !== out_data.status)
					$display("%0t: status exp %0d got %0d", $realtime, e.status,
						out_data.status);
				if (e !== out_data) fails++;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		fails = 0;
		cycles = 0;
		hold_cycles = 0;
		send_idle_pct = 6;
		recv_idle_pct = 86;
		for (int a = 0; a < MEMORY_BYTES; a++) mem[a] = (a < FONT_BYTES) ? FONT[a] : 8'd0;
		for (int r = 0; r < 16; r++) vreg[r] = 8'd0;
		for (int r = 0; r < STACK_DEPTH; r++) rstack[r] = 12'd0;
		for (int r = 0; r < FRAME_HEIGHT; r++) frame[r] = '0;
		ireg = 16'd0;
		pc = 12'(PROGRAM_START);
		sp = 0;
		delay_cnt = 8'd0;
		sound_cnt = 8'd0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		queue_directed();
		for (int i = 0; i < 550; i++) pending_items.push_back(program_item());
		wait (pending_items.size() == 0);
		send_idle_pct = 86;
		recv_idle_pct = 6;
		for (int i = 0; i < 550; i++) pending_items.push_back(program_item());
		wait (pending_items.size() == 0);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		@(posedge clk);
		hold_cycles <= 400;
		for (int i = 0; i < 575; i++) pending_items.push_back(program_item());
		wait (pending_items.size() == 0);
		@(posedge clk);
		while (in_valid || expected_results.size() > 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fails == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

@@ chip8_instruction_executor_top.f @@
hw/rtl/chip8_pkg.sv
hw/rtl/chip8_ctrl.sv
hw/rtl/chip8_dpath.sv
hw/rtl/chip8_instruction_executor_top.sv
hw/rtl/chip8_checker.sv
tb/sv/tb_chip8_instruction_executor_top.sv
